@@ sv/sipi_pkg.sv @@
// shared constants, codes and types of the subpixel interpolator
`default_nettype none

package sipi_pkg;

    // defaults of the top-level parameters
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // fixed field widths
    localparam int COORD_W     = 8;
    localparam int VALUE_W     = 16;
    localparam int QUERY_W     = 18;
    localparam int RESULT_W    = 32;
    localparam int DIM_W       = 9;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = DIM_W;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH   = 4'd0,
        REG_IMAGE_HEIGHT  = 4'd1,
        REG_BILINEAR_ONLY = 4'd2,
        REG_VARIANCE_MODE = 4'd3
    } reg_index_t;

    // per-stage control travelling with each item
    typedef struct packed {
        logic live;
        logic outside;
        logic bil;
    } ctl_t;

endpackage

`default_nettype wire

@@ sv/sipi_bank.sv @@
// one bank of the 3x3 banked pixel store, registered read
`default_nettype none

module sipi_bank #(
    parameter int DX  = 86,
    parameter int DY  = 86,
    parameter int AXW = 7,
    parameter int AYW = 7,
    parameter int PB  = 16
) (
    input  logic           aclk,
    input  logic           wr_en,
    input  logic [AXW-1:0] wr_x,
    input  logic [AYW-1:0] wr_y,
    input  logic [PB-1:0]  wr_data,
    input  logic           rd_en,
    input  logic [AXW-1:0] rd_x,
    input  logic [AYW-1:0] rd_y,
    output logic [PB-1:0]  rd_data
);

    logic [PB-1:0] mem [DY][DX];
    logic [PB-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_y][wr_x] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_y][rd_x];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/image_subpixel_interpolator_core.sv @@
// top level of the subpixel image interpolator
//
// input channel (s_*): each item either writes one pixel (s_operation = write)
//   into the pixel store or asks for the interpolated value at (query_x, query_y),
//   signed fixed point with FRAC_BITS fractional bits
// result channel (m_*): one item per query, none per write; interp_value carries
//   FRAC_BITS fractional bits, saturated to 32 bits
// config channel (cfg_*): always ready; write only while no item is in flight
// pixel store: nine banks (column mod 3, row mod 3) so the full 3x3 neighborhood
//   comes out of one read cycle; writes and reads share one pipeline stage, so an
//   item always sees every earlier write
// throughput: one item per cycle when not stalled, set by the single read slot of each bank
// path: a query passes the address, read, weights, optional squaring, products,
//   row sums, column products, accumulate, and round and saturate steps before
//   reaching the output register
// stall: the whole pipeline holds while a result waits on m_ready; s_ready is
//   high whenever the output register is empty or being taken
// reset: clears the pipeline and the registers (width/height 256, modes off);
//   the pixel store is not cleared, pixels must be written before being read
`default_nettype none

module image_subpixel_interpolator_core #(
    parameter int MAX_WIDTH  = sipi_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sipi_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = sipi_pkg::PIXEL_BITS_DEF,
    parameter int FRAC_BITS  = sipi_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // config write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sipi_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sipi_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input items
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  sipi_pkg::op_t                        s_operation,
    input  logic [sipi_pkg::COORD_W-1:0]         s_pixel_col,
    input  logic [sipi_pkg::COORD_W-1:0]         s_pixel_row,
    input  logic signed [sipi_pkg::VALUE_W-1:0]  s_pixel_value,
    input  logic signed [sipi_pkg::QUERY_W-1:0]  s_query_x,
    input  logic signed [sipi_pkg::QUERY_W-1:0]  s_query_y,
    // result items
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [sipi_pkg::RESULT_W-1:0] m_interp_value,
    output logic                                 m_outside,
    output logic                                 m_used_bilinear
);

    import sipi_pkg::*;

    // position arithmetic width (query plus headroom)
    localparam int XW  = QUERY_W + 2;
    localparam int CW0 = ($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                         $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT);
    localparam int CRW = (CW0 > COORD_W) ? CW0 : COORD_W;
    // bank geometry
    localparam int DX  = MAX_WIDTH / 3 + 1;
    localparam int DY  = MAX_HEIGHT / 3 + 1;
    localparam int AXW = ($clog2(DX) > 1) ? $clog2(DX) : 1;
    localparam int AYW = ($clog2(DY) > 1) ? $clog2(DY) : 1;
    // arithmetic widths
    localparam int PB  = PIXEL_BITS;
    localparam int WB  = 2 * FRAC_BITS + 1;     // weight fraction bits
    localparam int DW  = FRAC_BITS + 3;         // axis offset
    localparam int WW  = 2 * FRAC_BITS + 4;     // raw weight
    localparam int FW  = 2 * FRAC_BITS + 6;     // weight after optional squaring
    localparam int PW  = FW + PB;               // weight times pixel
    localparam int RSW = PW + 2;                // row sum
    localparam int GW  = FW + RSW;              // row times column weight
    localparam int AW  = GW + 2;                // accumulator
    localparam int RSH = 2 * WB - FRAC_BITS;    // final rounding shift
    localparam int DIV3_S = CRW + 2;

    localparam logic signed [XW-1:0] ONE_X  = XW'(1);
    localparam logic signed [XW-1:0] TWO_X  = XW'(2);
    localparam logic signed [XW-1:0] HALF_X = XW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [WW-1:0] ONE_W  = WW'(1) <<< FRAC_BITS;
    localparam logic signed [WW-1:0] SQ_ONE = WW'(1) <<< (2 * FRAC_BITS);
    localparam logic signed [WW-1:0] ONE_WB = WW'(1) <<< WB;
    localparam logic signed [2*WW-1:0] SQ_HALF  = (2 * WW)'(1) <<< (WB - 1);
    localparam logic signed [AW-1:0]   ACC_HALF = AW'(1) <<< (RSH - 1);
    localparam logic signed [AW-1:0]   SAT_MAX  = (AW'(1) <<< (RESULT_W - 1)) - AW'(1);
    localparam logic signed [AW-1:0]   SAT_MIN  = -(AW'(1) <<< (RESULT_W - 1));
    localparam logic [2*CRW+1:0] DIV3_K = ((2 * CRW + 2)'(1) << DIV3_S) / 3 + 1;

    typedef enum logic [1:0] {
        AX_QUAD,
        AX_LIN,
        AX_SINGLE
    } axis_kind_t;

    typedef struct packed {
        axis_kind_t           kind;
        logic signed [DW-1:0] d;
        logic [CRW-1:0]       org;
    } axis_t;

    typedef struct packed {
        logic [CRW-1:0] q;
        logic [1:0]     m;
    } div3_t;

    typedef logic [2:0][WW-1:0] w3_t;

    // ---------------------------------------------------------------- helpers

    // divide by three through a reciprocal multiply, remainder by back-multiply
    function automatic div3_t div3(input logic [CRW-1:0] v);
        logic [2*CRW+1:0] p;
        logic [CRW-1:0]   q;
        logic [CRW-1:0]   t;
        div3_t            r;
        p   = (2 * CRW + 2)'(v) * DIV3_K;
        q   = p[DIV3_S +: CRW];
        t   = v - ((q << 1) + q);
        r.q = q;
        r.m = t[1:0];
        return r;
    endfunction

    // (m + i) mod 3 for m, i in 0..2
    function automatic logic [1:0] rot3(input logic [1:0] m, input logic [1:0] i);
        logic [2:0] s;
        s = 3'(m) + 3'(i);
        return (s >= 3'd3) ? 2'(s - 3'd3) : 2'(s);
    endfunction

    // per-axis mode, offset and origin of the neighborhood
    function automatic axis_t axis_setup(input logic signed [XW-1:0] q,
                                         input logic signed [XW-1:0] r,
                                         input logic signed [XW-1:0] n,
                                         input logic                 bil);
        axis_t                a;
        logic signed [XW-1:0] b;
        logic signed [XW-1:0] org;
        logic signed [XW-1:0] d;
        b = q >>> FRAC_BITS;
        if (b < 0) begin
            b = '0;
        end else if (b >= n - ONE_X) begin
            b = n - TWO_X;
        end
        if (!bil) begin
            a.kind = AX_QUAD;
            org    = r - ONE_X;
            d      = q - (r <<< FRAC_BITS);
        end else if (n <= ONE_X) begin
            a.kind = AX_SINGLE;
            org    = '0;
            d      = '0;
        end else begin
            // offset from the clamped base extrapolates past the edge
            a.kind = AX_LIN;
            org    = b;
            d      = q - (b <<< FRAC_BITS);
        end
        a.d   = d[DW-1:0];
        a.org = org[CRW-1:0];
        return a;
    endfunction

    function automatic logic [2:0] tap_mask(input axis_kind_t k);
        case (k)
            AX_QUAD:   return 3'b111;
            AX_LIN:    return 3'b011;
            AX_SINGLE: return 3'b001;
            default:   return 3'b000;
        endcase
    endfunction

    // one-dimensional weights with WB fraction bits
    function automatic w3_t axis_weights(input axis_kind_t k, input logic signed [DW-1:0] d);
        logic signed [WW-1:0] dd;
        logic signed [WW-1:0] w0;
        logic signed [WW-1:0] w1;
        logic signed [WW-1:0] w2;
        dd = WW'(d);
        case (k)
            AX_QUAD: begin
                w0 = dd * (dd - ONE_W);
                w1 = (SQ_ONE - dd * dd) <<< 1;
                w2 = dd * (dd + ONE_W);
            end
            AX_LIN: begin
                w0 = (ONE_W - dd) <<< (FRAC_BITS + 1);
                w1 = dd <<< (FRAC_BITS + 1);
                w2 = '0;
            end
            AX_SINGLE: begin
                w0 = ONE_WB;
                w1 = '0;
                w2 = '0;
            end
            default: begin
                w0 = '0;
                w1 = '0;
                w2 = '0;
            end
        endcase
        return {w2, w1, w0};
    endfunction

    // square a weight and round back to WB bits, halves up
    function automatic logic signed [FW-1:0] sq_round(input logic signed [WW-1:0] w);
        logic signed [2*WW-1:0] sq;
        logic signed [2*WW-1:0] sh;
        sq = (2 * WW)'(w) * (2 * WW)'(w);
        sh = (sq + SQ_HALF) >>> WB;
        return FW'(sh);
    endfunction

    // ---------------------------------------------------------------- config

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             bilinear_reg;
    logic             variance_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= DIM_W'(256);
            height_reg   <= DIM_W'(256);
            bilinear_reg <= 1'b0;
            variance_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg    <= cfg_data;
                REG_IMAGE_HEIGHT:  height_reg   <= cfg_data;
                REG_BILINEAR_ONLY: bilinear_reg <= cfg_data[0];
                REG_VARIANCE_MODE: variance_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective image size, clamped to 1..max
    logic signed [XW-1:0] nx;
    logic signed [XW-1:0] ny;

    always_comb begin
        if (width_reg == '0) begin
            nx = ONE_X;
        end else if (int'(width_reg) > MAX_WIDTH) begin
            nx = XW'(MAX_WIDTH);
        end else begin
            nx = XW'(width_reg);
        end
        if (height_reg == '0) begin
            ny = ONE_X;
        end else if (int'(height_reg) > MAX_HEIGHT) begin
            ny = XW'(MAX_HEIGHT);
        end else begin
            ny = XW'(height_reg);
        end
    end

    // ---------------------------------------------------------------- pipeline

    // whole pipeline moves when the output register can take a new item
    logic adv;
    logic m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // stage a: accepted item
    logic                         a_valid_reg;
    op_t                          a_op_reg;
    logic [COORD_W-1:0]           a_col_reg;
    logic [COORD_W-1:0]           a_row_reg;
    logic signed [VALUE_W-1:0]    a_value_reg;
    logic signed [QUERY_W-1:0]    a_qx_reg;
    logic signed [QUERY_W-1:0]    a_qy_reg;

    // stage a logic: rounding, region tests, bank addressing
    logic signed [XW-1:0] qx;
    logic signed [XW-1:0] qy;
    logic signed [XW-1:0] xr;
    logic signed [XW-1:0] yr;
    logic                 a_outside;
    logic                 a_bil;
    axis_t                ax;
    axis_t                ay;
    div3_t                rdx;
    div3_t                rdy;
    div3_t                wdx;
    div3_t                wdy;
    logic                 wr_go;
    logic [31:0]          pix_ext;
    logic [PB-1:0]        wr_data;
    logic [AXW-1:0]       rd_x [3];
    logic [AYW-1:0]       rd_y [3];
    ctl_t                 a_ctl;

    always_comb begin
        qx        = XW'(a_qx_reg);
        qy        = XW'(a_qy_reg);
        xr        = (qx + HALF_X) >>> FRAC_BITS;
        yr        = (qy + HALF_X) >>> FRAC_BITS;
        a_outside = (xr < 0) || (yr < 0) || (xr > nx) || (yr > ny);
        a_bil     = bilinear_reg || (xr < ONE_X) || (yr < ONE_X) ||
                    (xr > nx - TWO_X) || (yr > ny - TWO_X);
        ax        = axis_setup(qx, xr, nx, a_bil);
        ay        = axis_setup(qy, yr, ny, a_bil);
        rdx       = div3(ax.org);
        rdy       = div3(ay.org);
        // bank k holds the neighborhood column whose index mod 3 is k
        for (int k = 0; k < 3; k++) begin
            rd_x[k] = rdx.q[AXW-1:0] + AXW'(rdx.m > 2'(k));
            rd_y[k] = rdy.q[AYW-1:0] + AYW'(rdy.m > 2'(k));
        end
        wdx     = div3(CRW'(a_col_reg));
        wdy     = div3(CRW'(a_row_reg));
        wr_go   = adv && a_valid_reg && (a_op_reg == OP_WRITE) &&
                  (int'(a_col_reg) < MAX_WIDTH) && (int'(a_row_reg) < MAX_HEIGHT);
        // low PIXEL_BITS of the zero-extended field, read as signed
        pix_ext = {{(32 - VALUE_W){1'b0}}, a_value_reg};
        wr_data = pix_ext[PB-1:0];
        a_ctl.live    = a_valid_reg && (a_op_reg == OP_QUERY);
        a_ctl.outside = a_outside;
        a_ctl.bil     = a_bil;
    end

    // pixel store banks
    logic [PB-1:0] bank_rdata [3][3];

    for (genvar by = 0; by < 3; by++) begin : g_row
        for (genvar bx = 0; bx < 3; bx++) begin : g_col
            sipi_bank #(
                .DX  (DX),
                .DY  (DY),
                .AXW (AXW),
                .AYW (AYW),
                .PB  (PB)
            ) u_bank (
                .aclk    (aclk),
                .wr_en   (wr_go && (wdy.m == 2'(by)) && (wdx.m == 2'(bx))),
                .wr_x    (wdx.q[AXW-1:0]),
                .wr_y    (wdy.q[AYW-1:0]),
                .wr_data (wr_data),
                .rd_en   (adv),
                .rd_x    (rd_x[bx]),
                .rd_y    (rd_y[by]),
                .rd_data (bank_rdata[by][bx])
            );
        end
    end

    // stage b: bank data arrives
    ctl_t                 b_ctl_reg;
    axis_kind_t           b_kx_reg;
    axis_kind_t           b_ky_reg;
    logic signed [DW-1:0] b_dx_reg;
    logic signed [DW-1:0] b_dy_reg;
    logic [1:0]           b_m0x_reg;
    logic [1:0]           b_m0y_reg;

    w3_t                  b_wx;
    w3_t                  b_wy;
    logic signed [PB-1:0] b_pix [3][3];

    always_comb begin : b_logic
        logic [1:0] sx;
        logic [1:0] sy;
        logic [2:0] mx;
        logic [2:0] my;
        b_wx = axis_weights(b_kx_reg, b_dx_reg);
        b_wy = axis_weights(b_ky_reg, b_dy_reg);
        mx   = tap_mask(b_kx_reg);
        my   = tap_mask(b_ky_reg);
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                sx = rot3(b_m0x_reg, 2'(i));
                sy = rot3(b_m0y_reg, 2'(j));
                // taps that the axis mode leaves unused have zero weight and are forced to zero
                b_pix[j][i] = (mx[i] && my[j]) ? bank_rdata[sy][sx] : '0;
            end
        end
    end

    // stage c: raw weights and neighborhood
    ctl_t                 c_ctl_reg;
    logic signed [WW-1:0] c_wx_reg [3];
    logic signed [WW-1:0] c_wy_reg [3];
    logic signed [PB-1:0] c_pix_reg [3][3];

    logic signed [FW-1:0] c_fx [3];
    logic signed [FW-1:0] c_fy [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_fx[i] = variance_reg ? sq_round(c_wx_reg[i]) : FW'(c_wx_reg[i]);
            c_fy[i] = variance_reg ? sq_round(c_wy_reg[i]) : FW'(c_wy_reg[i]);
        end
    end

    // stage d: final weights
    ctl_t                 d_ctl_reg;
    logic signed [FW-1:0] d_wx_reg [3];
    logic signed [FW-1:0] d_wy_reg [3];
    logic signed [PB-1:0] d_pix_reg [3][3];

    logic signed [PW-1:0] d_prod [3][3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                d_prod[j][i] = PW'(d_wx_reg[i]) * PW'(d_pix_reg[j][i]);
            end
        end
    end

    // stage e: products along x
    ctl_t                 e_ctl_reg;
    logic signed [PW-1:0] e_prod_reg [3][3];
    logic signed [FW-1:0] e_wy_reg [3];

    logic signed [RSW-1:0] e_row [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            e_row[j] = RSW'(e_prod_reg[j][0]) + RSW'(e_prod_reg[j][1]) +
                       RSW'(e_prod_reg[j][2]);
        end
    end

    // stage f: row sums
    ctl_t                  f_ctl_reg;
    logic signed [RSW-1:0] f_row_reg [3];
    logic signed [FW-1:0]  f_wy_reg [3];

    logic signed [GW-1:0] f_term [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            f_term[j] = GW'(f_wy_reg[j]) * GW'(f_row_reg[j]);
        end
    end

    // stage g: weighted rows
    ctl_t                 g_ctl_reg;
    logic signed [GW-1:0] g_term_reg [3];

    logic signed [AW-1:0] g_acc;

    assign g_acc = AW'(g_term_reg[0]) + AW'(g_term_reg[1]) + AW'(g_term_reg[2]);

    // stage h: accumulated sum, then round and saturate
    ctl_t                         h_ctl_reg;
    logic signed [AW-1:0]         h_acc_reg;
    logic signed [AW-1:0]         h_rnd;
    logic signed [RESULT_W-1:0]   h_res;

    always_comb begin
        h_rnd = (h_acc_reg + ACC_HALF) >>> RSH;
        if (h_rnd > SAT_MAX) begin
            h_res = RESULT_W'(SAT_MAX);
        end else if (h_rnd < SAT_MIN) begin
            h_res = RESULT_W'(SAT_MIN);
        end else begin
            h_res = h_rnd[RESULT_W-1:0];
        end
    end

    // output register
    logic signed [RESULT_W-1:0] m_interp_value_reg;
    logic                       m_outside_reg;
    logic                       m_used_bilinear_reg;

    // control: valid bits of every stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_ctl_reg   <= '0;
            c_ctl_reg   <= '0;
            d_ctl_reg   <= '0;
            e_ctl_reg   <= '0;
            f_ctl_reg   <= '0;
            g_ctl_reg   <= '0;
            h_ctl_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
            b_ctl_reg   <= a_ctl;
            c_ctl_reg   <= b_ctl_reg;
            d_ctl_reg   <= c_ctl_reg;
            e_ctl_reg   <= d_ctl_reg;
            f_ctl_reg   <= e_ctl_reg;
            g_ctl_reg   <= f_ctl_reg;
            h_ctl_reg   <= g_ctl_reg;
            m_valid_reg <= h_ctl_reg.live;
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_op_reg    <= s_operation;
            a_col_reg   <= s_pixel_col;
            a_row_reg   <= s_pixel_row;
            a_value_reg <= s_pixel_value;
            a_qx_reg    <= s_query_x;
            a_qy_reg    <= s_query_y;

            b_kx_reg  <= ax.kind;
            b_ky_reg  <= ay.kind;
            b_dx_reg  <= ax.d;
            b_dy_reg  <= ay.d;
            b_m0x_reg <= rdx.m;
            b_m0y_reg <= rdy.m;

            for (int i = 0; i < 3; i++) begin
                c_wx_reg[i] <= $signed(b_wx[i]);
                c_wy_reg[i] <= $signed(b_wy[i]);
                d_wx_reg[i] <= c_fx[i];
                d_wy_reg[i] <= c_fy[i];
                e_wy_reg[i] <= d_wy_reg[i];
                f_wy_reg[i] <= e_wy_reg[i];
                f_row_reg[i]  <= e_row[i];
                g_term_reg[i] <= f_term[i];
            end
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    c_pix_reg[j][i]  <= b_pix[j][i];
                    d_pix_reg[j][i]  <= c_pix_reg[j][i];
                    e_prod_reg[j][i] <= d_prod[j][i];
                end
            end
            h_acc_reg <= g_acc;

            if (h_ctl_reg.live) begin
                // outside the image: zero value, bilinear flag clear
                m_interp_value_reg  <= h_ctl_reg.outside ? '0 : h_res;
                m_outside_reg       <= h_ctl_reg.outside;
                m_used_bilinear_reg <= !h_ctl_reg.outside && h_ctl_reg.bil;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_interp_value  = m_interp_value_reg;
    assign m_outside       = m_outside_reg;
    assign m_used_bilinear = m_used_bilinear_reg;

endmodule

`default_nettype wire

@@ sv/sipi_checker.sv @@
// port-level checks of the subpixel interpolator, bound to the top level
`default_nettype none

module sipi_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [sipi_pkg::RESULT_W-1:0] m_interp_value,
    input logic                                 m_outside,
    input logic                                 m_used_bilinear
);

    import sipi_pkg::*;

    // reset empties the result register
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an outside query reports zero with the bilinear flag clear
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_outside) |-> ((m_interp_value == '0) && !m_used_bilinear))
        else $error("outside result not zero");

    // an empty output stage never blocks input
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_interp_value) &&
                                   $stable(m_outside) && $stable(m_used_bilinear)))
        else $error("stalled result changed");

endmodule

bind image_subpixel_interpolator_core sipi_checker u_sipi_checker (.*);

`default_nettype wire
